FILE: sv/permutation_unrank_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permutation unrank unit
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_UNIT_MACROS_SVH
`define PERMUTATION_UNRANK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/punrk_pkg.sv
// ----------------------------------------------------------------------------
// Permutation unrank package
// Widths, limits and the control structs between the sequencer and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package punrk_pkg;

  localparam int MaxNDefault = 12;
  localparam int RankW       = 31;
  localparam int SizeW       = 4;
  localparam int ElemW       = 4;

  // The quotient is divided eight bits per cycle over a 32-bit word.
  localparam int DivWordW    = 32;
  localparam int ChunkW      = 8;
  localparam int NumChunks   = DivWordW / ChunkW;
  localparam int ChunkCntW   = $clog2(NumChunks);

  typedef struct packed {
    logic             go;
    logic             ld;
    logic [SizeW-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [SizeW-1:0] rem;
  } div_stat_t;

endpackage

FILE: sv/punrk_divider.sv
// ----------------------------------------------------------------------------
// Permutation unrank divider
// Holds the running quotient and divides it by a small divisor, eight
// quotient bits per cycle, leaving the remainder for the pool pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module punrk_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  punrk_pkg::div_cmd_t      cmd_i,
  input  logic [punrk_pkg::RankW-1:0] rank_i,
  output punrk_pkg::div_stat_t     stat_o
);
  import punrk_pkg::*;

  logic                 busy_q, busy_d;
  logic [ChunkCntW-1:0] cnt_q, cnt_d;
  logic [DivWordW-1:0]  quo_q, quo_d;
  logic [SizeW-1:0]     rem_q, rem_d;
  logic [SizeW-1:0]     div_q, div_d;

  logic [ChunkW-1:0]    chunk;
  logic [ChunkW-1:0]    qbits;
  logic [SizeW-1:0]     rem_step;
  logic                 last_chunk;

  assign chunk      = quo_q[DivWordW-1 -: ChunkW];
  assign last_chunk = (cnt_q == ChunkCntW'(NumChunks - 1));

  // Restoring division of one chunk; the partial remainder stays below the
  // divisor, so it never needs more than one extra bit.
  always_comb begin
    logic [SizeW:0]   trial;
    logic [SizeW-1:0] r;
    r     = rem_q;
    qbits = '0;
    for (int i = ChunkW - 1; i >= 0; i--) begin
      trial = {r, chunk[i]};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        qbits[i] = 1'b1;
      end
      r = trial[SizeW-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (cmd_i.go) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = cmd_i.divisor;
      if (cmd_i.ld) begin
        quo_d = {1'b0, rank_i};
      end
    end else if (busy_q) begin
      quo_d = {quo_q[DivWordW-ChunkW-1:0], qbits};
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (last_chunk) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.done = busy_q & last_chunk;
  assign stat_o.rem  = rem_q;

endmodule

FILE: sv/permutation_unrank_unit.sv
// ----------------------------------------------------------------------------
// Permutation unrank unit
// Decodes a rank into a permutation of 0..n-1, one element per result,
// least significant factoradic digit first.
// ----------------------------------------------------------------------------
//
// Channel   Ports                       Transfer
// input     start_i, rank_i, size_i     start_i high while busy_o low
// result    valid_o, element_o, last_o  every cycle with valid_o high
//
// While an item of size n is worked on, busy_o stays high: each element takes
// four passes of the shared divider (eight quotient bits per cycle over the
// 32-bit quotient word) and then a pick state that removes the pool entry.
// An item of size zero is taken and produces nothing. Reset is asynchronous
// and active low and leaves the unit idle. Results cannot be held off; each
// one is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_unrank_unit #(
  parameter int MAX_N = punrk_pkg::MaxNDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [punrk_pkg::RankW-1:0]  rank_i,
  input  logic [punrk_pkg::SizeW-1:0]  size_i,
  output logic                         busy_o,
  output logic                         valid_o,
  output logic [punrk_pkg::ElemW-1:0]  element_o,
  output logic                         last_o
);
  import punrk_pkg::*;

  localparam int IdxW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPick = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [SizeW-1:0] left_q, left_d;
  logic [ElemW-1:0] pool_q [MAX_N];
  logic [ElemW-1:0] pool_d [MAX_N];
  logic             valid_q, valid_d;
  logic [ElemW-1:0] elem_q, elem_d;
  logic             last_q, last_d;

  div_cmd_t         div_cmd;
  div_stat_t        div_stat;

  logic             accept;
  logic [SizeW-1:0] size_clamped;
  logic [IdxW-1:0]  sel;

  assign accept       = start_i & (state_q == StIdle);
  assign size_clamped = (size_i > SizeW'(MAX_N)) ? SizeW'(MAX_N) : size_i;
  assign sel          = div_stat.rem[IdxW-1:0];

  punrk_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rank_i (rank_i),
    .stat_o (div_stat)
  );

  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    pool_d  = pool_q;
    valid_d = 1'b0;
    elem_d  = elem_q;
    last_d  = last_q;
    div_cmd = '0;
    case (state_q)
      StIdle: begin
        if (accept && (size_i != '0)) begin
          for (int k = 0; k < MAX_N; k++) begin
            pool_d[k] = ElemW'(k);
          end
          left_d          = size_clamped;
          div_cmd.go      = 1'b1;
          div_cmd.ld      = 1'b1;
          div_cmd.divisor = size_clamped;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          state_d = StPick;
        end
      end
      StPick: begin
        // The remainder selects the entry; everything above it moves down.
        valid_d = 1'b1;
        elem_d  = pool_q[sel];
        last_d  = (left_q == SizeW'(1));
        for (int k = 0; k < MAX_N - 1; k++) begin
          if (IdxW'(k) >= sel) begin
            pool_d[k] = pool_q[k+1];
          end
        end
        left_d = left_q - 1'b1;
        if (left_q == SizeW'(1)) begin
          state_d = StIdle;
        end else begin
          div_cmd.go      = 1'b1;
          div_cmd.divisor = left_q - 1'b1;
          state_d         = StDiv;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pool_q <= pool_d;
    elem_q <= elem_d;
    last_q <= last_d;
  end

  assign busy_o    = (state_q != StIdle);
  assign valid_o   = valid_q;
  assign element_o = elem_q;
  assign last_o    = last_q;

endmodule

FILE: sv/punrk_checker.sv
// ----------------------------------------------------------------------------
// Permutation unrank port checker
// Watches the unit's ports for sequencing and result marking errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "permutation_unrank_unit_macros.svh"

module punrk_checker #(
  parameter int MAX_N = punrk_pkg::MaxNDefault
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic [punrk_pkg::RankW-1:0]  rank_i,
  input logic [punrk_pkg::SizeW-1:0]  size_i,
  input logic                         busy_o,
  input logic                         valid_o,
  input logic [punrk_pkg::ElemW-1:0]  element_o,
  input logic                         last_o
);
  import punrk_pkg::*;

  logic take;
  assign take = start_i & !busy_o;

  `PU_ASSERT_IMPL(a_elem_range, clk_i, rst_ni, valid_o, element_o < ElemW'(MAX_N), "element out of range")

  // A size-one item yields element zero, marked last, after one full divide.
  `PU_ASSERT_IMPL(a_single, clk_i, rst_ni, take && size_i == SizeW'(1), ##6 (valid_o && last_o && element_o == '0), "size one result wrong")

  `PU_ASSERT_NEXT(a_mid_gap, clk_i, rst_ni, valid_o && !last_o, busy_o && !valid_o, "results too close")

  `PU_ASSERT_IMPL(a_last_idle, clk_i, rst_ni, valid_o && last_o, !busy_o, "busy after final element")

  `PU_ASSERT_NEXT(a_empty, clk_i, rst_ni, take && size_i == '0 && rank_i == rank_i, !busy_o && !valid_o, "empty item started work")

endmodule

bind permutation_unrank_unit punrk_checker #(.MAX_N(MAX_N)) u_punrk_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .rank_i    (rank_i),
  .size_i    (size_i),
  .busy_o    (busy_o),
  .valid_o   (valid_o),
  .element_o (element_o),
  .last_o    (last_o)
);
